// ----- design/plb_pkg.sv -----
// ============================================================================
// plb_pkg: shared types and constants of the price level order book
// Holds the status codes, the stream field widths and the cell control group.
// ============================================================================
package plb_pkg;

    // Widths of the fixed stream fields.
    localparam int FIELD_BITS    = 32;
    localparam int IN_DATA_BITS  = 64;
    localparam int IN_USER_BITS  = 2;
    localparam int OUT_DATA_BITS = 136;
    localparam int OUT_USER_BITS = 3;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - 4 * FIELD_BITS - 2;

    // Status code reported with every result.
    typedef enum logic [OUT_USER_BITS-1:0] {
        STATUS_CHANGED  = 3'd0,
        STATUS_INSERTED = 3'd1,
        STATUS_REMOVED  = 3'd2,
        STATUS_MISSED   = 3'd3,
        STATUS_DROPPED  = 3'd4,
        STATUS_CLEARED  = 3'd5
    } status_t;

    // Control group driven by the sequencer into each side's chain of cells.
    typedef struct packed {
        logic cmp_en;    // cells latch their compare flags
        logic apply_en;  // cells take their next contents
        logic clear;     // apply empties the side
        logic remove;    // apply removes the matching level
    } plb_ctrl_t;

endpackage

// ----- design/price_level_order_book.sv -----
// ============================================================================
// price_level_order_book: bid and ask price level tables with best of book
// Applies clear and level update requests and reports best bid, best ask
// and a status code for every request.
// ============================================================================
//
// Channel   Dir  Handshake          Content
// s_*       in   s_tvalid/s_tready  level update or clear request
// m_*       out  m_tvalid/m_tready  best bid, best ask and status
//
// Each request is accepted, compared in all cells, applied as a shift or
// overwrite, then loaded into the result register. The cell chain is busy
// for the whole request, so the next one is accepted only after that load.
// A result waiting in the output register does not hold back the next
// accept; it only stalls the final load of the following request.
// Reset empties both sides at once through the per-level valid bits.
//
module price_level_order_book #(
    parameter int LEVEL_DEPTH   = 64,
    parameter int PRICE_BITS    = 32,
    parameter int QUANTITY_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // level_price [31:0], level_quantity [63:32]
    input  logic [plb_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // cmd [0], book_side [1]
    input  logic [plb_pkg::IN_USER_BITS-1:0]   s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // best_bid_valid [0], best_bid_price [32:1], best_bid_quantity [64:33],
    // best_ask_valid [65], best_ask_price [97:66], best_ask_quantity [129:98],
    // zero fill [135:130]
    output logic [plb_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    // status [2:0]
    output logic [plb_pkg::OUT_USER_BITS-1:0]  m_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY,
        ST_DONE
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic                               cmd_reg;
    logic                               side_reg;
    logic [PRICE_BITS-1:0]              price_reg;
    logic [QUANTITY_BITS-1:0]           qty_reg;
    plb_pkg::status_t                   status_reg;
    plb_pkg::status_t                   status_next;
    logic                               m_tvalid_reg;
    logic [plb_pkg::OUT_DATA_BITS-1:0]  m_tdata_reg;
    plb_pkg::status_t                   m_tuser_reg;

    logic                               accept;
    logic                               out_free;
    plb_pkg::plb_ctrl_t                 bid_ctrl;
    plb_pkg::plb_ctrl_t                 ask_ctrl;

    logic                               bid_valid;
    logic [PRICE_BITS-1:0]              bid_price;
    logic [QUANTITY_BITS-1:0]           bid_qty;
    logic                               bid_hit;
    logic                               bid_full;
    logic                               ask_valid;
    logic [PRICE_BITS-1:0]              ask_price;
    logic [QUANTITY_BITS-1:0]           ask_qty;
    logic                               ask_hit;
    logic                               ask_full;
    logic                               sel_hit;
    logic                               sel_full;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Both sides see the compare phase; only the addressed side applies,
    // except for a clear, which empties both.
    always_comb
    begin
        bid_ctrl.cmp_en   = (state_reg == ST_CMP);
        bid_ctrl.apply_en = (state_reg == ST_APPLY) && (cmd_reg || !side_reg);
        bid_ctrl.clear    = cmd_reg;
        bid_ctrl.remove   = (qty_reg == '0);
        ask_ctrl          = bid_ctrl;
        ask_ctrl.apply_en = (state_reg == ST_APPLY) && (cmd_reg || side_reg);
    end

    plb_side #(
        .IS_ASK        (1'b0),
        .LEVEL_DEPTH   (LEVEL_DEPTH),
        .PRICE_BITS    (PRICE_BITS),
        .QUANTITY_BITS (QUANTITY_BITS)
    ) u_bid (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (bid_ctrl),
        .new_price  (price_reg),
        .new_qty    (qty_reg),
        .best_valid (bid_valid),
        .best_price (bid_price),
        .best_qty   (bid_qty),
        .hit_any    (bid_hit),
        .full       (bid_full)
    );

    plb_side #(
        .IS_ASK        (1'b1),
        .LEVEL_DEPTH   (LEVEL_DEPTH),
        .PRICE_BITS    (PRICE_BITS),
        .QUANTITY_BITS (QUANTITY_BITS)
    ) u_ask (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ask_ctrl),
        .new_price  (price_reg),
        .new_qty    (qty_reg),
        .best_valid (ask_valid),
        .best_price (ask_price),
        .best_qty   (ask_qty),
        .hit_any    (ask_hit),
        .full       (ask_full)
    );

    assign sel_hit  = side_reg ? ask_hit : bid_hit;
    assign sel_full = side_reg ? ask_full : bid_full;

    // The status follows from the compare flags latched in the previous cycle.
    always_comb
    begin
        priority if (cmd_reg)
        begin
            status_next = plb_pkg::STATUS_CLEARED;
        end
        else if (qty_reg == '0)
        begin
            status_next = sel_hit ? plb_pkg::STATUS_REMOVED : plb_pkg::STATUS_MISSED;
        end
        else if (sel_hit)
        begin
            status_next = plb_pkg::STATUS_CHANGED;
        end
        else if (sel_full)
        begin
            status_next = plb_pkg::STATUS_DROPPED;
        end
        else
        begin
            status_next = plb_pkg::STATUS_INSERTED;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_CMP;
            ST_CMP:   state_next = ST_APPLY;
            ST_APPLY: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer state, request payload and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cmd_reg      <= 1'b0;
            side_reg     <= 1'b0;
            price_reg    <= '0;
            qty_reg      <= '0;
            status_reg   <= plb_pkg::STATUS_CHANGED;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= plb_pkg::STATUS_CHANGED;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cmd_reg   <= s_tuser[0];
                side_reg  <= s_tuser[1];
                price_reg <= PRICE_BITS'(s_tdata[plb_pkg::FIELD_BITS-1:0]);
                qty_reg   <= QUANTITY_BITS'(
                    s_tdata[2*plb_pkg::FIELD_BITS-1:plb_pkg::FIELD_BITS]);
            end
            if (state_reg == ST_APPLY)
            begin
                status_reg <= status_next;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {{plb_pkg::OUT_PAD_BITS{1'b0}},
                                 plb_pkg::FIELD_BITS'(ask_qty),
                                 plb_pkg::FIELD_BITS'(ask_price),
                                 ask_valid,
                                 plb_pkg::FIELD_BITS'(bid_qty),
                                 plb_pkg::FIELD_BITS'(bid_price),
                                 bid_valid};
                m_tuser_reg  <= status_reg;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- design/plb_cell.sv -----
// ============================================================================
// plb_cell: one price level of a sorted side
// Holds one level, compares it with the request and shifts with its neighbors.
// ============================================================================
module plb_cell #(
    parameter bit IS_ASK        = 1'b0,
    parameter int PRICE_BITS    = 32,
    parameter int QUANTITY_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  plb_pkg::plb_ctrl_t       ctrl,
    input  logic [PRICE_BITS-1:0]    new_price,
    input  logic [QUANTITY_BITS-1:0] new_qty,
    input  logic                     hit_any,
    input  logic                     left_ahead,
    input  logic                     left_valid,
    input  logic [PRICE_BITS-1:0]    left_price,
    input  logic [QUANTITY_BITS-1:0] left_qty,
    input  logic                     right_valid,
    input  logic [PRICE_BITS-1:0]    right_price,
    input  logic [QUANTITY_BITS-1:0] right_qty,
    output logic                     valid,
    output logic [PRICE_BITS-1:0]    price,
    output logic [QUANTITY_BITS-1:0] qty,
    output logic                     ahead,
    output logic                     hit
);

    logic                     valid_reg;
    logic                     valid_next;
    logic [PRICE_BITS-1:0]    price_reg;
    logic [PRICE_BITS-1:0]    price_next;
    logic [QUANTITY_BITS-1:0] qty_reg;
    logic [QUANTITY_BITS-1:0] qty_next;
    logic                     ahead_reg;
    logic                     hit_reg;
    logic                     ranks_ahead;

    // A level ranks ahead when it is better than the requested price.
    assign ranks_ahead = IS_ASK ? (price_reg < new_price) : (price_reg > new_price);

    always_comb
    begin
        valid_next = valid_reg;
        price_next = price_reg;
        qty_next   = qty_reg;
        if (ctrl.apply_en)
        begin
            priority if (ctrl.clear)
            begin
                valid_next = 1'b0;
            end
            else if (ctrl.remove)
            begin
                // Every cell from the removed level on takes its right neighbor.
                if (hit_any && !ahead_reg)
                begin
                    valid_next = right_valid;
                    price_next = right_price;
                    qty_next   = right_qty;
                end
            end
            else if (hit_any)
            begin
                if (hit_reg)
                begin
                    qty_next = new_qty;
                end
            end
            else if (!ahead_reg)
            begin
                // Insert: the first cell behind the price takes the new level,
                // the cells after it shift one place back.
                if (left_ahead)
                begin
                    valid_next = 1'b1;
                    price_next = new_price;
                    qty_next   = new_qty;
                end
                else
                begin
                    valid_next = left_valid;
                    price_next = left_price;
                    qty_next   = left_qty;
                end
            end
            else
            begin
                // A level ahead of the inserted price keeps its place.
                valid_next = valid_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ahead_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.cmp_en)
            begin
                ahead_reg <= valid_reg && ranks_ahead;
                hit_reg   <= valid_reg && (price_reg == new_price);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        qty_reg   <= qty_next;
    end

    assign valid = valid_reg;
    assign price = price_reg;
    assign qty   = qty_reg;
    assign ahead = ahead_reg;
    assign hit   = hit_reg;

endmodule

// ----- design/plb_side.sv -----
// ============================================================================
// plb_side: one side of the book as a chain of level cells
// Links the cells to their neighbors and reports the best level and flags.
// ============================================================================
module plb_side #(
    parameter bit IS_ASK        = 1'b0,
    parameter int LEVEL_DEPTH   = 64,
    parameter int PRICE_BITS    = 32,
    parameter int QUANTITY_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  plb_pkg::plb_ctrl_t       ctrl,
    input  logic [PRICE_BITS-1:0]    new_price,
    input  logic [QUANTITY_BITS-1:0] new_qty,
    output logic                     best_valid,
    output logic [PRICE_BITS-1:0]    best_price,
    output logic [QUANTITY_BITS-1:0] best_qty,
    output logic                     hit_any,
    output logic                     full
);

    logic [LEVEL_DEPTH-1:0]   valid_w;
    logic [LEVEL_DEPTH-1:0]   ahead_w;
    logic [LEVEL_DEPTH-1:0]   hit_w;
    logic [PRICE_BITS-1:0]    price_w [LEVEL_DEPTH];
    logic [QUANTITY_BITS-1:0] qty_w   [LEVEL_DEPTH];

    for (genvar i = 0; i < LEVEL_DEPTH; i++)
    begin : g_cell
        logic                     l_ahead;
        logic                     l_valid;
        logic [PRICE_BITS-1:0]    l_price;
        logic [QUANTITY_BITS-1:0] l_qty;
        logic                     r_valid;
        logic [PRICE_BITS-1:0]    r_price;
        logic [QUANTITY_BITS-1:0] r_qty;

        if (i == 0)
        begin : g_head
            // The head has nothing ahead of it, so an insert stops here.
            assign l_ahead = 1'b1;
            assign l_valid = 1'b0;
            assign l_price = '0;
            assign l_qty   = '0;
        end
        else
        begin : g_body
            assign l_ahead = ahead_w[i-1];
            assign l_valid = valid_w[i-1];
            assign l_price = price_w[i-1];
            assign l_qty   = qty_w[i-1];
        end

        if (i == LEVEL_DEPTH - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_price = '0;
            assign r_qty   = '0;
        end
        else
        begin : g_inner
            assign r_valid = valid_w[i+1];
            assign r_price = price_w[i+1];
            assign r_qty   = qty_w[i+1];
        end

        plb_cell #(
            .IS_ASK        (IS_ASK),
            .PRICE_BITS    (PRICE_BITS),
            .QUANTITY_BITS (QUANTITY_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_price   (new_price),
            .new_qty     (new_qty),
            .hit_any     (hit_any),
            .left_ahead  (l_ahead),
            .left_valid  (l_valid),
            .left_price  (l_price),
            .left_qty    (l_qty),
            .right_valid (r_valid),
            .right_price (r_price),
            .right_qty   (r_qty),
            .valid       (valid_w[i]),
            .price       (price_w[i]),
            .qty         (qty_w[i]),
            .ahead       (ahead_w[i]),
            .hit         (hit_w[i])
        );
    end

    // At most one cell matches, since the prices of a side are distinct.
    assign hit_any    = |hit_w;
    assign full       = valid_w[LEVEL_DEPTH-1];
    assign best_valid = valid_w[0];
    assign best_price = valid_w[0] ? price_w[0] : '0;
    assign best_qty   = valid_w[0] ? qty_w[0] : '0;

endmodule

// ----- design/plb_checker.sv -----
// ============================================================================
// plb_checker: port level checks of the price level order book
// Watches the stream ports and flags results that cannot be right.
// ============================================================================
module plb_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [plb_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    input logic [plb_pkg::OUT_USER_BITS-1:0]  m_tuser
);

    // A stalled result holds its content.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The book works on one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    // An empty bid side reports zero price and quantity.
    a_empty_bid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[64:1] == '0))
        else $error("empty bid side reports a level");

    // The status is always a defined code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= plb_pkg::STATUS_CLEARED))
        else $error("undefined status code");

    // After a clear both sides are empty.
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == plb_pkg::STATUS_CLEARED) |-> !m_tdata[0] && !m_tdata[65])
        else $error("book not empty after clear");

endmodule

bind price_level_order_book plb_checker u_plb_checker (.*);
